/* design/ihcd_pkg.sv */
// ----------------------------------------------------------------------------
// ihcd_pkg: shared types and constants for the IPv4 header check / demux
// Word structs, header record passed from parser to verdict stage, codes.
// ----------------------------------------------------------------------------
package ihcd_pkg;

  localparam int MAX_CONNS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 64;

  localparam logic [4:0]  MIN_HDR_WORDS  = 5'd10;
  localparam logic [15:0] BASE_HDR_BYTES = 16'd20;
  localparam logic [4:0]  CKSUM_POS      = 5'd5;
  localparam logic [4:0]  LAST_POS       = 5'd31;

  // status codes
  localparam logic [2:0] ST_DELIVERED  = 3'd0;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd1;
  localparam logic [2:0] ST_BAD_VER    = 3'd2;
  localparam logic [2:0] ST_BAD_CKSUM  = 3'd3;
  localparam logic [2:0] ST_NOT_OURS   = 3'd4;
  localparam logic [2:0] ST_FRAGMENT   = 3'd5;
  localparam logic [2:0] ST_NO_HANDLER = 3'd6;

  // register indexes (paddr[4:3])
  localparam logic [1:0] REG_LOCAL_ADDR = 2'd0;
  localparam logic [1:0] REG_CONN_COUNT = 2'd1;
  localparam logic [1:0] REG_CONN_PROTO = 2'd2;
  localparam logic [1:0] REG_CONN_HNDL  = 2'd3;

  typedef struct packed {
    logic [15:0] header_word;
    logic [15:0] frame_length;
    logic        first_word;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  protocol;
    logic [31:0] source_address;
    logic [15:0] payload_length;
    logic [2:0]  connection_index;
  } out_word_t;

  // everything the verdict needs, captured at the last header word
  typedef struct packed {
    logic        short_hdr;
    logic [15:0] rx_len;
    logic [15:0] tot_len;
    logic [3:0]  version;
    logic [15:0] sum;
    logic [15:0] cksum;
    logic [31:0] dst;
    logic        frag;
    logic [7:0]  proto;
    logic [31:0] src;
  } hdr_rec_t;

  typedef struct packed {
    logic [31:0] local_addr;
    logic [3:0]  conn_count;
    logic [63:0] conn_protos;
    logic [7:0]  conn_handled;
  } cfg_regs_t;

endpackage

/* design/ihcd_parse.sv */
// ----------------------------------------------------------------------------
// ihcd_parse: header word parser
// Tracks word position, folds the ones-complement sum and captures fields;
// emits one header record on the last header word.
// ----------------------------------------------------------------------------
module ihcd_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ihcd_pkg::in_word_t in_data,
  input  logic              q_full,
  output logic              rec_push,
  output ihcd_pkg::hdr_rec_t rec_data
);
  import ihcd_pkg::*;

  logic [4:0]  word_idx_r, word_idx_nxt;
  logic [4:0]  hdr_words_r, hdr_words_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [15:0] rx_len_r, rx_len_nxt;
  logic [3:0]  version_r, version_nxt;
  logic [15:0] tot_len_r, tot_len_nxt;
  logic        frag_r, frag_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] cksum_r, cksum_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;

  logic        in_fire;
  logic [4:0]  pos;
  logic        start;
  logic [4:0]  end_w;
  logic [15:0] base_sum;
  logic [16:0] sum17;
  logic [15:0] folded;
  logic        in_range;
  logic        last;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    pos      = in_data.first_word ? 5'd0 : word_idx_r;
    start    = (pos == 5'd0);
    hdr_words_nxt = start ? {in_data.header_word[11:8], 1'b0} : hdr_words_r;
    end_w    = (hdr_words_nxt < MIN_HDR_WORDS) ? MIN_HDR_WORDS : hdr_words_nxt;
    base_sum = start ? 16'd0 : sum_r;
    sum17    = {1'b0, base_sum} + {1'b0, in_data.header_word};
    folded   = sum17[15:0] + {15'd0, sum17[16]};   // end-around carry
    in_range = (pos < end_w);
    last     = in_range && (({1'b0, pos} + 6'd1) == {1'b0, end_w});
  end

  always_comb begin
    word_idx_nxt = (pos == LAST_POS) ? LAST_POS : pos + 5'd1;
    rx_len_nxt   = start ? in_data.frame_length : rx_len_r;
    version_nxt  = start ? in_data.header_word[15:12] : version_r;
    sum_nxt      = base_sum;
    tot_len_nxt  = tot_len_r;
    frag_nxt     = frag_r;
    proto_nxt    = proto_r;
    cksum_nxt    = cksum_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    if (in_range) begin
      if (pos != CKSUM_POS) sum_nxt = folded;
      case (pos)
        5'd1: tot_len_nxt = in_data.header_word;
        5'd3: frag_nxt    = (in_data.header_word[13:0] != 14'd0);
        5'd4: proto_nxt   = in_data.header_word[7:0];
        5'd5: cksum_nxt   = in_data.header_word;
        5'd6: src_nxt[31:16] = in_data.header_word;
        5'd7: src_nxt[15:0]  = in_data.header_word;
        5'd8: dst_nxt[31:16] = in_data.header_word;
        5'd9: dst_nxt[15:0]  = in_data.header_word;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_idx_r <= '0;
    end else if (in_fire) begin
      word_idx_r <= word_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hdr_words_r <= hdr_words_nxt;
      sum_r       <= sum_nxt;
      rx_len_r    <= rx_len_nxt;
      version_r   <= version_nxt;
      tot_len_r   <= tot_len_nxt;
      frag_r      <= frag_nxt;
      proto_r     <= proto_nxt;
      cksum_r     <= cksum_nxt;
      src_r       <= src_nxt;
      dst_r       <= dst_nxt;
    end
  end

  assign rec_push = in_fire && last;

  always_comb begin
    rec_data.short_hdr = (hdr_words_nxt < MIN_HDR_WORDS);
    rec_data.rx_len    = rx_len_nxt;
    rec_data.tot_len   = tot_len_nxt;
    rec_data.version   = version_nxt;
    rec_data.sum       = sum_nxt;
    rec_data.cksum     = cksum_nxt;
    rec_data.dst       = dst_nxt;
    rec_data.frag      = frag_nxt;
    rec_data.proto     = proto_nxt;
    rec_data.src       = src_nxt;
  end

endmodule

/* design/ihcd_queue.sv */
// ----------------------------------------------------------------------------
// ihcd_queue: header record queue
// Small circular FIFO between parser and verdict stage.
// ----------------------------------------------------------------------------
module ihcd_queue #(
  parameter int DEPTH = ihcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ihcd_pkg::hdr_rec_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output ihcd_pkg::hdr_rec_t head_data
);
  import ihcd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  hdr_rec_t        slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

/* design/ihcd_verdict.sv */
// ----------------------------------------------------------------------------
// ihcd_verdict: verdict and protocol demux
// Applies the checks in priority order, looks up the connection table and
// holds the result word in an output register.
// ----------------------------------------------------------------------------
module ihcd_verdict #(
  parameter int MAX_CONNS = ihcd_pkg::MAX_CONNS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ihcd_pkg::cfg_regs_t cfg,
  input  logic                rec_valid,
  input  ihcd_pkg::hdr_rec_t  rec,
  output logic                rec_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output ihcd_pkg::out_word_t out_data
);
  import ihcd_pkg::*;

  logic        out_valid_r;
  out_word_t   out_data_r, out_data_nxt;
  logic [3:0]  n_conns;
  logic        found;
  logic        handled;
  logic [2:0]  match_idx;

  assign rec_pop = rec_valid && (!out_valid_r || out_ready);

  // first matching entry below the effective count decides
  always_comb begin
    n_conns   = (cfg.conn_count > 4'(MAX_CONNS)) ? 4'(MAX_CONNS) : cfg.conn_count;
    found     = 1'b0;
    handled   = 1'b0;
    match_idx = 3'd0;
    for (int i = 0; i < MAX_CONNS; i++) begin
      if (!found && (4'(i) < n_conns) && (cfg.conn_protos[8*i +: 8] == rec.proto)) begin
        found     = 1'b1;
        handled   = cfg.conn_handled[i];
        match_idx = 3'(i);
      end
    end
  end

  always_comb begin
    out_data_nxt.protocol         = rec.proto;
    out_data_nxt.source_address   = rec.src;
    out_data_nxt.payload_length   = (rec.tot_len > BASE_HDR_BYTES) ?
                                    rec.tot_len - BASE_HDR_BYTES : 16'd0;
    out_data_nxt.connection_index = 3'd0;
    if (rec.short_hdr || (rec.rx_len < rec.tot_len)) begin
      out_data_nxt.status = ST_BAD_LENGTH;
    end else if (rec.version != 4'd4) begin
      out_data_nxt.status = ST_BAD_VER;
    end else if (rec.cksum != ~rec.sum) begin
      out_data_nxt.status = ST_BAD_CKSUM;
    end else if ((rec.dst != cfg.local_addr) && (rec.dst[7:0] != 8'd0)) begin
      // zero last octet counts as broadcast
      out_data_nxt.status = ST_NOT_OURS;
    end else if (rec.frag) begin
      out_data_nxt.status = ST_FRAGMENT;
    end else if (found && handled) begin
      out_data_nxt.status           = ST_DELIVERED;
      out_data_nxt.connection_index = match_idx;
    end else begin
      out_data_nxt.status = ST_NO_HANDLER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rec_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/ipv4_header_check_demux.sv */
// ----------------------------------------------------------------------------
// ipv4_header_check_demux: IPv4 header check and protocol demultiplexer
// Parses header words, checks length/version/checksum/address/fragment and
// picks the receiving connection for the protocol.
// ----------------------------------------------------------------------------
//  port group   dir    payload       accepted when
//  in_*         in     in_word_t     in_valid & in_ready
//  out_*        out    out_word_t    out_valid & out_ready
//  p* (APB)     in     64-bit regs   psel & penable & pwrite (pready = 1)
//
// One header word per cycle while the queue is not full; after the last header
// word the record is queued, then the verdict is registered at the output.
// The queue of header records decouples the parser from a stalled output;
// the parser stalls only when the queue is full.
// Synchronous active-low reset clears positions, queue, output valid and config registers.
// ----------------------------------------------------------------------------
module ipv4_header_check_demux #(
  parameter int MAX_CONNS   = ihcd_pkg::MAX_CONNS_DEF,
  parameter int QUEUE_DEPTH = ihcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ihcd_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ihcd_pkg::out_word_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ihcd_pkg::ADDR_W-1:0]   paddr,
  input  logic [ihcd_pkg::DATA_W-1:0]   pwdata,
  output logic [ihcd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import ihcd_pkg::*;

  cfg_regs_t cfg_r;
  logic      cfg_wr;
  logic [1:0] reg_idx;

  logic      q_full, rec_push, rec_valid, rec_pop;
  hdr_rec_t  rec_in, rec_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LOCAL_ADDR: cfg_r.local_addr   <= pwdata[31:0];
        REG_CONN_COUNT: cfg_r.conn_count   <= pwdata[3:0];
        REG_CONN_PROTO: cfg_r.conn_protos  <= pwdata;
        REG_CONN_HNDL:  cfg_r.conn_handled <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LOCAL_ADDR: prdata = {32'd0, cfg_r.local_addr};
      REG_CONN_COUNT: prdata = {60'd0, cfg_r.conn_count};
      REG_CONN_PROTO: prdata = cfg_r.conn_protos;
      REG_CONN_HNDL:  prdata = {56'd0, cfg_r.conn_handled};
      default:        prdata = '0;
    endcase
  end

  ihcd_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .rec_push (rec_push),
    .rec_data (rec_in)
  );

  ihcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (rec_push),
    .push_data  (rec_in),
    .full       (q_full),
    .pop        (rec_pop),
    .head_valid (rec_valid),
    .head_data  (rec_head)
  );

  ihcd_verdict #(
    .MAX_CONNS (MAX_CONNS)
  ) u_verdict (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .rec_valid (rec_valid),
    .rec       (rec_head),
    .rec_pop   (rec_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
